>>> rtl/core/ipv4p_pkg.sv
// shared types and constants for the dotted-decimal ipv4 parser
package ipv4p_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned OctetWidth  = 8;
  // accumulator holds up to the saturation value 256
  localparam int unsigned AccWidth    = 9;
  localparam int unsigned UpperWidth  = 24;
  // widest value of acc * 10 + digit before saturation
  localparam int unsigned ProdWidth   = 12;

  localparam logic [CharWidth-1:0] ChSpace = 8'h20;
  localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
  localparam logic [CharWidth-1:0] ChDot   = 8'h2E;
  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChNine  = 8'h39;

  localparam logic [AccWidth-1:0] OctetMax = 9'd255;
  localparam logic [AccWidth-1:0] AccSat   = 9'd256;
  localparam logic [1:0]          LastOctet = 2'd3;

  typedef enum logic [1:0] {
    PH_SPACES = 2'd0,
    PH_PLUS   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 3'd0,
    ST_NODIGIT = 3'd1,
    ST_RANGE   = 3'd2,
    ST_SEP     = 3'd3,
    ST_PLUS    = 3'd4
  } status_t;

  typedef struct packed {
    logic                  finished;
    logic [1:0]            octet_index;
    phase_t                field_phase;
    logic [AccWidth-1:0]   octet_value;
    logic [UpperWidth-1:0] upper_octets;
  } parse_state_t;

  typedef struct packed {
    logic                 emit;
    status_t              status;
    logic [AddrWidth-1:0] address;
  } parse_result_t;

endpackage

>>> rtl/core/ipv4p_char_if.sv
// character channel: one text character per word
interface ipv4p_char_if;
  import ipv4p_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 start_req;

  modport source (output valid, output character, output start_req, input ready);
  modport sink (input valid, input character, input start_req, output ready);
endinterface

>>> rtl/core/ipv4p_res_if.sv
// result channel: status and parsed address per word
interface ipv4p_res_if;
  import ipv4p_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [StatusWidth-1:0] status;
  logic [AddrWidth-1:0]   address;

  modport source (output valid, output status, output address, input ready);
  modport sink (input valid, input status, input address, output ready);
endinterface

>>> rtl/core/ipv4p_step.sv
// one-character parse step: next state and optional result
module ipv4p_step (
  input  ipv4p_pkg::parse_state_t       cur,
  input  logic [ipv4p_pkg::CharWidth-1:0] character,
  input  logic                          start_req,
  output ipv4p_pkg::parse_state_t       nxt,
  output ipv4p_pkg::parse_result_t      res
);
  import ipv4p_pkg::*;

  parse_state_t          s;
  parse_state_t          cleared;
  logic                  is_digit;
  logic                  take_digit;
  logic [ProdWidth-1:0]  prod;
  logic [AccWidth-1:0]   acc_sat;

  assign is_digit = (character >= ChZero) && (character <= ChNine);

  // acc * 10 + digit as two shifts and adds
  assign prod = {cur.octet_value, 3'b000} + {2'b00, cur.octet_value, 1'b0}
              + {{(ProdWidth-4){1'b0}}, character[3:0]};
  assign acc_sat = (prod > {{(ProdWidth-AccWidth){1'b0}}, AccSat}) ? AccSat
                                                                   : prod[AccWidth-1:0];

  always_comb begin
    cleared              = '0;
    cleared.field_phase  = PH_SPACES;
    cleared.finished     = 1'b0;

    s = start_req ? cleared : cur;
    nxt        = s;
    res.emit   = 1'b0;
    res.status = ST_OK;
    res.address = '0;
    take_digit = 1'b0;

    if (!s.finished) begin
      unique case (s.field_phase)
        PH_SPACES: begin
          if (character == ChSpace) begin
            nxt.field_phase = PH_SPACES;
          end else if (character == ChPlus) begin
            nxt.field_phase = PH_PLUS;
          end else if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_NODIGIT;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_PLUS: begin
          if (character == ChPlus) begin
            res.emit   = 1'b1;
            res.status = ST_PLUS;
          end else if (!is_digit) begin
            res.emit   = 1'b1;
            res.status = ST_NODIGIT;
          end else begin
            take_digit = 1'b1;
          end
        end
        default: begin
          // in digits; the unused phase code behaves the same
          if (character == ChPlus) begin
            res.emit   = 1'b1;
            res.status = ST_PLUS;
          end else if (!is_digit) begin
            if (s.octet_value > OctetMax) begin
              res.emit   = 1'b1;
              res.status = ST_RANGE;
            end else if (s.octet_index == LastOctet) begin
              res.emit    = 1'b1;
              res.status  = ST_OK;
              res.address = {s.upper_octets, s.octet_value[OctetWidth-1:0]};
            end else if (character != ChDot) begin
              res.emit   = 1'b1;
              res.status = ST_SEP;
            end else begin
              nxt.upper_octets = {s.upper_octets[UpperWidth-OctetWidth-1:0],
                                  s.octet_value[OctetWidth-1:0]};
              nxt.octet_index  = s.octet_index + 2'd1;
              nxt.octet_value  = '0;
              nxt.field_phase  = PH_SPACES;
            end
          end else begin
            take_digit = 1'b1;
          end
        end
      endcase

      if (take_digit) begin
        nxt.field_phase = PH_DIGITS;
        // on a start the accumulator is already zero
        nxt.octet_value = start_req ? {{(AccWidth-4){1'b0}}, character[3:0]} : acc_sat;
      end

      if (res.emit) begin
        nxt          = cleared;
        nxt.finished = 1'b1;
      end
    end
  end
endmodule

>>> rtl/core/ipv4_dotted_decimal_parser.sv
// Dotted-decimal IPv4 parser: takes one ASCII character per word on chars and
// gives at most one result word per address string on result, holding a status
// (0 ok, 1 missing digits, 2 octet over 255, 3 bad separator, 4 misplaced plus)
// and the 32-bit address with the first octet in the top byte (zero on error).
// A string begins at a character flagged with start_req, which also restarts
// any parse in progress; characters outside a string are taken and dropped.
// Each octet may have leading spaces and one '+', the first three end in '.',
// and the fourth ends at any character that is neither a digit nor '+'.
// Throughput is one character per clock when not held off: the per-character
// step is combinational logic feeding the parse state, and the result register
// shows the result the cycle after the terminating character. Input is held off
// only while a result waits in the result register and the sink is not ready.
module ipv4_dotted_decimal_parser (
  input logic   clk,
  input logic   rst,
  ipv4p_char_if.sink  chars,
  ipv4p_res_if.source result
);
  import ipv4p_pkg::*;

  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  logic          accept;

  ipv4p_step u_step (
    .cur       (state),
    .character (chars.character),
    .start_req (chars.start_req),
    .nxt       (state_next),
    .res       (step_res)
  );

  // result register parts the two sides
  assign chars.ready = !result.valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{finished: 1'b1, octet_index: 2'd0, field_phase: PH_SPACES,
                 octet_value: '0, upper_octets: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && step_res.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_res.emit) begin
      result.status  <= step_res.status;
      result.address <= step_res.address;
    end
  end
endmodule
